// ----- rtl/core/i2cram_pkg.sv -----
// shared types and constants for the i2c register access master
package i2cram_pkg;

  localparam int DevAddrWidth = 7;
  localparam int ByteWidth    = 8;
  localparam int BitsPerByte  = 8;

  // transfer sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_WBYTE = 4'd2,
    PH_READ  = 4'd3,
    PH_MNACK = 4'd4,
    PH_STOP  = 4'd5
  } phase_t;

  // byte currently being sent
  typedef enum logic [1:0] {
    SLOT_DEVW = 2'd0,
    SLOT_REG  = 2'd1,
    SLOT_DATA = 2'd2,
    SLOT_DEVR = 2'd3
  } slot_t;

  // error codes
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_DEVW = 3'd1;
  localparam logic [2:0] ERR_REG  = 3'd2;
  localparam logic [2:0] ERR_DATA = 3'd3;
  localparam logic [2:0] ERR_DEVR = 3'd4;

  localparam logic [1:0] Q_SETUP  = 2'd0;
  localparam logic [1:0] Q_RISE   = 2'd1;
  localparam logic [1:0] Q_SAMPLE = 2'd2;
  localparam logic [1:0] Q_FALL   = 2'd3;

  localparam logic [DevAddrWidth-1:0] DevAddrReset = 7'd67;

  // sequencer state carried from tick to tick
  typedef struct packed {
    phase_t                phase;
    logic [1:0]            quarter;
    logic [3:0]            bit_count;
    logic [ByteWidth-1:0]  shift_byte;
    slot_t                 slot;
    logic                  kind;
    logic [ByteWidth-1:0]  reg_address;
    logic [ByteWidth-1:0]  write_data;
    logic [ByteWidth-1:0]  received;
    logic [2:0]            last_error;
    logic                  scl;
    logic                  sda;
    logic                  drive;
  } state_t;

  // one result of a tick
  typedef struct packed {
    logic                  scl_level;
    logic                  sda_level;
    logic                  sda_drive;
    logic                  busy;
    logic                  done;
    logic [2:0]            error_code;
    logic [ByteWidth-1:0]  read_data;
  } result_t;

endpackage

// ----- rtl/core/i2cram_step.sv -----
// next state and result of one bus tick
module i2cram_step (
  input  i2cram_pkg::state_t                          cur,
  input  logic [i2cram_pkg::DevAddrWidth-1:0]          device_address,
  input  logic                                        start_request,
  input  logic                                        kind,
  input  logic [i2cram_pkg::ByteWidth-1:0]             reg_address,
  input  logic [i2cram_pkg::ByteWidth-1:0]             write_data,
  input  logic                                        sda_in,
  output i2cram_pkg::state_t                          nxt,
  output i2cram_pkg::result_t                         res
);
  import i2cram_pkg::*;

  logic [ByteWidth-1:0] dev_byte;
  assign dev_byte = {device_address, 1'b0};

  // sequencer for one quarter of a bus bit
  always_comb begin
    state_t     n;
    logic [1:0] q;
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    n    = cur;
    busy = 1'b0;
    done = 1'b0;
    q    = cur.quarter;
    scl  = 1'b0;
    sda  = 1'b1;
    drv  = 1'b1;
    // unknown phase codes fall back to idle
    if (!(n.phase inside {PH_START, PH_WBYTE, PH_READ, PH_MNACK, PH_STOP})) begin
      n.phase = PH_IDLE;
    end
    // new transaction on request while idle
    if (n.phase == PH_IDLE && start_request) begin
      n.kind        = kind;
      n.reg_address = reg_address;
      n.write_data  = write_data;
      n.last_error  = ERR_NONE;
      n.slot        = SLOT_DEVW;
      n.quarter     = Q_SETUP;
      n.bit_count   = 4'd0;
      n.phase       = PH_START;
    end
    if (n.phase != PH_IDLE) begin
      q    = n.quarter;
      scl  = (q == Q_RISE) || (q == Q_SAMPLE);
      busy = 1'b1;
      case (n.phase)
        PH_START: begin
          sda = (q == Q_SETUP) || (q == Q_RISE);
          if (q == Q_FALL) begin
            n.shift_byte = (n.slot == SLOT_DEVR) ? (dev_byte | 8'd1) : dev_byte;
            n.bit_count  = 4'd0;
            n.phase      = PH_WBYTE;
          end
        end
        PH_WBYTE: begin
          if (n.bit_count < 4'(BitsPerByte)) begin
            sda = n.shift_byte[3'd7 - n.bit_count[2:0]];
            if (q == Q_FALL) n.bit_count = n.bit_count + 4'd1;
          end else begin
            // ack slot, line released
            drv = 1'b0;
            if (q == Q_SAMPLE && sda_in) n.last_error = {1'b0, n.slot} + 3'd1;
            if (q == Q_FALL) begin
              n.bit_count = 4'd0;
              if (n.last_error != ERR_NONE) begin
                n.phase = PH_STOP;
              end else if (n.slot == SLOT_DEVW) begin
                n.slot       = SLOT_REG;
                n.shift_byte = n.reg_address;
              end else if (n.slot == SLOT_REG && !n.kind) begin
                n.slot       = SLOT_DATA;
                n.shift_byte = n.write_data;
              end else if (n.slot == SLOT_REG) begin
                n.slot  = SLOT_DEVR;
                n.phase = PH_START;
              end else if (n.slot == SLOT_DEVR) begin
                n.shift_byte = '0;
                n.phase      = PH_READ;
              end else begin
                n.phase = PH_STOP;
              end
            end
          end
        end
        PH_READ: begin
          drv = 1'b0;
          if (q == Q_SAMPLE) n.shift_byte = {n.shift_byte[ByteWidth-2:0], sda_in};
          if (q == Q_FALL) begin
            n.bit_count = n.bit_count + 4'd1;
            if (n.bit_count >= 4'(BitsPerByte)) begin
              n.received  = n.shift_byte;
              n.bit_count = 4'd0;
              n.phase     = PH_MNACK;
            end
          end
        end
        PH_MNACK: begin
          // master nack: sda stays high and driven
          if (q == Q_FALL) n.phase = PH_STOP;
        end
        default: begin
          // stop condition
          scl = (q != Q_SETUP);
          sda = (q == Q_SAMPLE) || (q == Q_FALL);
          if (q == Q_FALL) begin
            done    = 1'b1;
            n.phase = PH_IDLE;
          end
        end
      endcase
      n.scl     = scl;
      n.sda     = sda;
      n.drive   = drv;
      n.quarter = q + 2'd1;
    end
    nxt            = n;
    res.scl_level  = n.scl;
    res.sda_level  = n.drive ? n.sda : 1'b1;
    res.sda_drive  = n.drive;
    res.busy       = busy;
    res.done       = done;
    res.error_code = n.last_error;
    res.read_data  = n.received;
  end

endmodule

// ----- rtl/core/i2c_register_access_master.sv -----
// i2c register access master top level: state, config and result registers
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    start_request kind reg_address write_data sda_in
//   out       output     out_valid/out_ready  scl_level sda_level sda_drive busy_res done_res
//                                              error_code read_data
//   cfg       input      cfg_write            cfg_data (device address)
//
// one tick is accepted per cycle while in_ready is high; its result appears in the output register the next cycle.
// the tick logic sits between the state register and the result register in one pass.
// rst is synchronous; it sets device address 67, idle phase, lines high and driven.
// a stalled result holds in_ready low only while out_ready stays low.
module i2c_register_access_master (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [i2cram_pkg::DevAddrWidth-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 start_request,
  input  logic                                 kind,
  input  logic [i2cram_pkg::ByteWidth-1:0]     reg_address,
  input  logic [i2cram_pkg::ByteWidth-1:0]     write_data,
  input  logic                                 sda_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 scl_level,
  output logic                                 sda_level,
  output logic                                 sda_drive,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [2:0]                           error_code,
  output logic [i2cram_pkg::ByteWidth-1:0]     read_data
);
  import i2cram_pkg::*;

  logic [DevAddrWidth-1:0] device_address;
  state_t                  state;
  state_t                  state_next;
  result_t                 result;
  result_t                 result_next;
  logic                    accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DevAddrReset;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  i2cram_step u_step (
    .cur            (state),
    .device_address (device_address),
    .start_request  (start_request),
    .kind           (kind),
    .reg_address    (reg_address),
    .write_data     (write_data),
    .sda_in         (sda_in),
    .nxt            (state_next),
    .res            (result_next)
  );

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.quarter     <= 2'd0;
      state.bit_count   <= 4'd0;
      state.shift_byte  <= '0;
      state.slot        <= SLOT_DEVW;
      state.kind        <= 1'b0;
      state.reg_address <= '0;
      state.write_data  <= '0;
      state.received    <= '0;
      state.last_error  <= ERR_NONE;
      state.scl         <= 1'b1;
      state.sda         <= 1'b1;
      state.drive       <= 1'b1;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign scl_level  = result.scl_level;
  assign sda_level  = result.sda_level;
  assign sda_drive  = result.sda_drive;
  assign busy_res   = result.busy;
  assign done_res   = result.done;
  assign error_code = result.error_code;
  assign read_data  = result.read_data;

  // an accepted tick always leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result");

  // completion only happens inside a transaction
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res)
    else $error("done without busy");

  // a released line reads high and a done tick leaves the bus idle high
  a_done_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> scl_level && sda_level && sda_drive)
    else $error("stop did not leave both lines high");

endmodule

// ----- tb/sv/i2c_bus_checker.sv -----
// checker for the i2c register access master: models every tick and compares each result
module i2c_bus_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [i2cram_pkg::DevAddrWidth-1:0]  cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 start_request,
  input  logic                                 kind,
  input  logic [i2cram_pkg::ByteWidth-1:0]     reg_address,
  input  logic [i2cram_pkg::ByteWidth-1:0]     write_data,
  input  logic                                 sda_in,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 scl_level,
  input  logic                                 sda_level,
  input  logic                                 sda_drive,
  input  logic                                 busy_res,
  input  logic                                 done_res,
  input  logic [2:0]                           error_code,
  input  logic [i2cram_pkg::ByteWidth-1:0]     read_data,
  output int                                   mismatches,
  output int                                   outstanding
);
  import i2cram_pkg::*;

  // model copy of the sequencer and its device address
  logic [DevAddrWidth-1:0] dev_addr;
  phase_t                  ph;
  logic [1:0]              qs;
  logic [3:0]              bitc;
  logic [ByteWidth-1:0]    shb;
  slot_t                   slot;
  logic                    lk;
  logic [ByteWidth-1:0]    lreg;
  logic [ByteWidth-1:0]    ldata;
  logic [ByteWidth-1:0]    rxb;
  logic [2:0]              lerr;
  logic                    scl_q;
  logic                    sda_q;
  logic                    drv_q;

  // predicted bus lines and status, oldest first
  result_t expected_lines[$];

  // byte to shift out for a given slot; address read at load time
  function automatic logic [ByteWidth-1:0] slot_byte(slot_t s);
    case (s)
      SLOT_REG:  return lreg;
      SLOT_DATA: return ldata;
      SLOT_DEVR: return {dev_addr, 1'b1};
      default:   return {dev_addr, 1'b0};
    endcase
  endfunction

  // one timing tick of the bus sequencer
  function automatic result_t advance_bus(logic sr, logic k, logic [ByteWidth-1:0] ra,
                                          logic [ByteWidth-1:0] wd, logic sd);
    result_t r;
    logic [1:0] q;
    logic scl;
    logic sda;
    logic drv;
    logic busy;
    logic done;
    busy = 1'b0;
    done = 1'b0;
    // a request is taken only when idle
    if (ph == PH_IDLE && sr) begin
      lk    = k;
      lreg  = ra;
      ldata = wd;
      lerr  = ERR_NONE;
      slot  = SLOT_DEVW;
      qs    = Q_SETUP;
      bitc  = '0;
      ph    = PH_START;
    end
    if (ph != PH_IDLE) begin
      q    = qs;
      scl  = (q == Q_RISE || q == Q_SAMPLE);
      sda  = 1'b1;
      drv  = 1'b1;
      busy = 1'b1;
      case (ph)
        PH_START: begin
          sda = (q == Q_SETUP || q == Q_RISE);
          if (q == Q_FALL) begin
            shb  = slot_byte(slot);
            bitc = '0;
            ph   = PH_WBYTE;
          end
        end
        PH_WBYTE: begin
          if (bitc < BitsPerByte) begin
            sda = shb[ByteWidth - 1 - bitc];
            if (q == Q_FALL) bitc++;
          end else begin
            // ack bit: line released, target pulls low
            drv = 1'b0;
            sda = 1'b1;
            if (q == Q_SAMPLE && sd) begin
              case (slot)
                SLOT_DEVW: lerr = ERR_DEVW;
                SLOT_REG:  lerr = ERR_REG;
                SLOT_DATA: lerr = ERR_DATA;
                default:   lerr = ERR_DEVR;
              endcase
            end
            if (q == Q_FALL) begin
              bitc = '0;
              if (lerr != ERR_NONE) ph = PH_STOP;
              else if (slot == SLOT_DEVW) begin
                slot = SLOT_REG;
                shb  = slot_byte(slot);
              end else if (slot == SLOT_REG && !lk) begin
                slot = SLOT_DATA;
                shb  = slot_byte(slot);
              end else if (slot == SLOT_REG) begin
                slot = SLOT_DEVR;
                ph   = PH_START;
              end else if (slot == SLOT_DEVR) begin
                shb = '0;
                ph  = PH_READ;
              end else ph = PH_STOP;
            end
          end
        end
        PH_READ: begin
          drv = 1'b0;
          sda = 1'b1;
          if (q == Q_SAMPLE) shb = {shb[ByteWidth-2:0], sd};
          if (q == Q_FALL) begin
            bitc++;
            if (bitc >= BitsPerByte) begin
              rxb  = shb;
              bitc = '0;
              ph   = PH_MNACK;
            end
          end
        end
        PH_MNACK: begin
          if (q == Q_FALL) ph = PH_STOP;
        end
        PH_STOP: begin
          scl = (q != Q_SETUP);
          sda = (q == Q_SAMPLE || q == Q_FALL);
          if (q == Q_FALL) begin
            done = 1'b1;
            ph   = PH_IDLE;
          end
        end
        default: ph = PH_IDLE;
      endcase
      scl_q = scl;
      sda_q = sda;
      drv_q = drv;
      qs    = q + 2'd1;
    end
    r.scl_level  = scl_q;
    r.sda_level  = drv_q ? sda_q : 1'b1;
    r.sda_drive  = drv_q;
    r.busy       = busy;
    r.done       = done;
    r.error_code = lerr;
    r.read_data  = rxb;
    return r;
  endfunction

  // report one field, returns 1 on mismatch
  function automatic int check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // watch both channels and the config port
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      dev_addr = DevAddrReset;
      ph    = PH_IDLE;
      qs    = Q_SETUP;
      bitc  = '0;
      shb   = '0;
      slot  = SLOT_DEVW;
      lk    = 1'b0;
      lreg  = '0;
      ldata = '0;
      rxb   = '0;
      lerr  = ERR_NONE;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drv_q = 1'b1;
      expected_lines.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        got = {scl_level, sda_level, sda_drive, busy_res, done_res, error_code, read_data};
        if (expected_lines.size() == 0) begin
          $error("result transaction with no prediction waiting");
          errs++;
        end else begin
          want = expected_lines.pop_front();
          errs += check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
          errs += check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
          errs += check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
          errs += check_field("busy_res", 8'(want.busy), 8'(got.busy));
          errs += check_field("done_res", 8'(want.done), 8'(got.done));
          errs += check_field("error_code", 8'(want.error_code), 8'(got.error_code));
          errs += check_field("read_data", want.read_data, got.read_data);
        end
      end
      // tick transaction
      if (in_valid && in_ready)
        expected_lines.push_back(advance_bus(start_request, kind, reg_address,
                                             write_data, sda_in));
      if (cfg_write) dev_addr = cfg_data;
    end
    mismatches  <= mismatches + errs;
    outstanding <= expected_lines.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench top for the i2c register access master: stimulus, bus target behavior, verdict
module testbench;
  import i2cram_pkg::*;

  // tick schedule of one transfer, counted from the accepting tick
  localparam int QuarterTicks = 4;
  localparam int StartTicks   = QuarterTicks;
  localparam int ByteTicks    = (BitsPerByte + 1) * QuarterTicks;
  localparam int StopTicks    = QuarterTicks;
  localparam int NoNack       = -1;

  typedef enum int {REQ_QUIET, REQ_RANDOM, REQ_ALWAYS} req_mode_t;

  logic                    clk;
  logic                    rst           = 1'b1;
  logic                    cfg_write     = 1'b0;
  logic [DevAddrWidth-1:0] cfg_data      = '0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic                    start_request = 1'b0;
  logic                    kind          = 1'b0;
  logic [ByteWidth-1:0]    reg_address   = '0;
  logic [ByteWidth-1:0]    write_data    = '0;
  logic                    sda_in        = 1'b1;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic                    scl_level;
  logic                    sda_level;
  logic                    sda_drive;
  logic                    busy_res;
  logic                    done_res;
  logic [2:0]              error_code;
  logic [ByteWidth-1:0]    read_data;

  int   mismatches;
  int   outstanding;
  logic calm = 1'b0;
  int   n_xfers = 0;
  int   n_reads = 0;
  int   n_nacks = 0;
  int   xfer_ticks = 0;
  int   n_addrs = 0;

  i2c_register_access_master u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_request(start_request),
    .kind         (kind),
    .reg_address  (reg_address),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scl_level    (scl_level),
    .sda_level    (sda_level),
    .sda_drive    (sda_drive),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .error_code   (error_code),
    .read_data    (read_data)
  );

  i2c_bus_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_request(start_request),
    .kind         (kind),
    .reg_address  (reg_address),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scl_level    (scl_level),
    .sda_level    (sda_level),
    .sda_drive    (sda_drive),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .error_code   (error_code),
    .read_data    (read_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 24);
  end

  // one tick transaction, with random idle cycles ahead of it unless calm is set
  task automatic send_tick(input logic sr, input logic k, input logic [ByteWidth-1:0] ra,
                           input logic [ByteWidth-1:0] wd, input logic sd);
    logic took;
    if (!calm) begin
      while ($urandom_range(0, 99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    start_request <= sr;
    kind          <= k;
    reg_address   <= ra;
    write_data    <= wd;
    sda_in        <= sd;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // write the device address once every prediction has been matched
  task automatic set_device(input logic [DevAddrWidth-1:0] addr);
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_write <= 1'b0;
    n_addrs++;
  endtask

  // one whole transfer; sda_in acts as the target: acks, nacks and read bits
  task automatic run_transfer(input logic k, input logic [ByteWidth-1:0] ra,
                              input logic [ByteWidth-1:0] wd, input logic [ByteWidth-1:0] rbyte,
                              input int nack_at, input req_mode_t req);
    int acks[3];
    int rbase;
    int len;
    logic sr;
    logic sd;
    acks[0] = StartTicks + ByteTicks - 2;
    acks[1] = StartTicks + 2 * ByteTicks - 2;
    acks[2] = StartTicks + 3 * ByteTicks - 2 + (k ? StartTicks : 0);
    rbase   = 2 * StartTicks + 3 * ByteTicks;
    if (nack_at != NoNack) len = acks[nack_at] + 2 + StopTicks;
    else if (k) len = rbase + BitsPerByte * QuarterTicks + QuarterTicks + StopTicks;
    else len = StartTicks + 3 * ByteTicks + StopTicks;
    for (int t = 0; t < len; t++) begin
      sd = 1'($urandom_range(0, 1));
      for (int b = 0; b < 3; b++)
        if (t == acks[b]) sd = (b == nack_at);
      // read bits sampled in the second high quarter
      if (k && t >= rbase && t < rbase + BitsPerByte * QuarterTicks &&
          (t - rbase) % QuarterTicks == 2)
        sd = rbyte[BitsPerByte - 1 - (t - rbase) / QuarterTicks];
      case (req)
        REQ_QUIET:  sr = 1'b0;
        REQ_RANDOM: sr = 1'($urandom_range(0, 1));
        default:    sr = 1'b1;
      endcase
      if (t == 0) send_tick(1'b1, k, ra, wd, sd);
      else send_tick(sr, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), sd);
    end
    n_xfers++;
    if (k) n_reads++;
    if (nack_at != NoNack) n_nacks++;
    xfer_ticks += len;
  endtask

  // stimulus and verdict
  initial begin
    logic [DevAddrWidth-1:0] phase_addr[2];
    int phase_start;
    req_mode_t req;
    phase_addr[0] = 7'($urandom);
    phase_addr[1] = 7'h55;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, each nack point, requests while busy and on the done tick
    run_transfer(1'b0, 8'h00, 8'hFF, 8'h00, NoNack, REQ_QUIET);
    set_device(7'h7F);
    run_transfer(1'b0, 8'hFF, 8'h00, 8'h00, NoNack, REQ_QUIET);
    run_transfer(1'b1, 8'h5A, 8'h00, 8'hA5, NoNack, REQ_QUIET);
    run_transfer(1'b1, 8'h00, 8'hFF, 8'hFF, NoNack, REQ_RANDOM);
    run_transfer(1'b0, 8'h33, 8'hCC, 8'h00, 0, REQ_QUIET);
    run_transfer(1'b0, 8'h44, 8'hBB, 8'h00, 1, REQ_QUIET);
    run_transfer(1'b0, 8'h55, 8'hAA, 8'h00, 2, REQ_QUIET);
    run_transfer(1'b1, 8'h66, 8'h99, 8'h0F, 2, REQ_QUIET);
    run_transfer(1'b1, 8'h77, 8'h88, 8'hF0, 1, REQ_ALWAYS);
    run_transfer(1'b1, 8'h88, 8'h77, 8'hF0, 0, REQ_QUIET);
    set_device(7'h00);
    run_transfer(1'b0, 8'h81, 8'h7E, 8'h00, NoNack, REQ_ALWAYS);
    run_transfer(1'b1, 8'hFF, 8'h00, 8'h00, NoNack, REQ_ALWAYS);
    run_transfer(1'b1, 8'h3C, 8'hC3, 8'h3C, NoNack, REQ_QUIET);

    // random transfers on two more device addresses, the second without idling
    for (int p = 0; p < 2; p++) begin
      set_device(phase_addr[p]);
      calm = (p == 1);
      phase_start = xfer_ticks;
      while (xfer_ticks - phase_start < 40) begin
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 6))
            send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
        end
        req = req_mode_t'($urandom_range(0, 2));
        run_transfer(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(0, 99) < 80) ? NoNack : int'($urandom_range(0, 2)),
                     req);
      end
    end
    calm = 1'b0;

    // drain
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (5) @(posedge clk);

    $display("covered %0d transfers (%0d reads, %0d ended by a target nack)",
             n_xfers, n_reads, n_nacks);
    $display("over %0d transfer ticks and %0d device address changes", xfer_ticks, n_addrs);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/i2cram_pkg.sv
rtl/core/i2cram_step.sv
rtl/core/i2c_register_access_master.sv
tb/sv/i2c_bus_checker.sv
tb/sv/testbench.sv
